/* hw/rtl/lnss_pkg.sv */
// Package for the longest non-positive-sum span search: sizes, widths and state codes.
`default_nettype none

package lnss_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned Depth      = MaxSamples + 1;
  localparam int unsigned AddrW      = $clog2(Depth);
  // counts and walk indices must reach MaxSamples + 1
  localparam int unsigned CntW       = $clog2(MaxSamples + 2);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned SumW       = 28;
  localparam int unsigned SpanW      = 11;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic [CntW-1:0]           cnt_t;
  typedef logic [AddrW-1:0]          addr_t;
  typedef logic [SpanW-1:0]          span_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StSuf  = 5'b00010,
    StWpre = 5'b00100,
    StWalk = 5'b01000,
    StDone = 5'b10000
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/longest_nonpositive_sum_span.sv */
// Top level: longest run of offset-shifted samples with sum at most zero.
//
//  channel  | direction | ports                                | handshake
//  ---------+-----------+--------------------------------------+---------------------------
//  item in  | in        | sample_i, last_i                     | start && !busy
//  result   | out       | span_length_o, overflow_o            | done_o, one cycle, no stall
//  config   | in        | offset_i                             | offset_we_i
//
// Loading takes one sample per cycle; busy stays low while samples stream in.
// A last sample starts the search over n stored samples: a backward suffix-min
// pass, a state that primes the walk, a two-pointer walk and a result state.
// The memory read ports (one per store, registered data) set the
// one-step-per-cycle pace.
// Reset clears control and the offset; the stores hold no reset state.
// The result is shown for one cycle only; the receiver cannot hold it off.
`default_nettype none

module longest_nonpositive_sum_span (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire lnss_pkg::sample_t sample_i,
  input  wire logic            last_i,
  input  wire logic            offset_we_i,
  input  wire lnss_pkg::sample_t offset_i,
  output logic                 done_o,
  output lnss_pkg::span_t      span_length_o,
  output logic                 overflow_o
);
  import lnss_pkg::*;

  // control state
  state_e state_q, state_d;
  sample_t offset_q;
  sum_t    sum_q, sum_d;
  cnt_t    cnt_q, cnt_d;          // stored samples, n during the search
  logic    ovf_q, ovf_d;
  // suffix pass
  cnt_t    k_q, k_d;              // next index to fetch
  logic    iss_done_q, iss_done_d;
  logic    iss_v_q, iss_v_d;      // a fetched P entry arrives this cycle
  cnt_t    iss_idx_q, iss_idx_d;
  sum_t    min_q, min_d;
  // walk
  cnt_t    i_q, i_d, j_q, j_d;
  sum_t    lm_q, lm_d;            // max of P seen so far, up to P[i-1] or P[i]
  cnt_t    best_q, best_d;

  // memories
  sum_t  pmem [Depth];
  sum_t  smem [Depth];
  logic  p_we, p_re, s_we, s_re;
  addr_t p_waddr, p_raddr, s_waddr, s_raddr;
  sum_t  p_wdata, s_wdata;
  sum_t  p_rdata_q, s_rdata_q;
  logic  p_zero_q;                // P[0] is implicitly zero

  // shared compare unit
  sum_t  cmp_a, cmp_b;
  logic  cmp_le;

  logic  accept;
  sum_t  p_val, lm_cur, samp_ext, off_ext;

  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign samp_ext = {{(SumW-SampleW){sample_i[SampleW-1]}}, sample_i};
  assign off_ext  = {{(SumW-SampleW){offset_q[SampleW-1]}}, offset_q};
  assign p_val    = p_zero_q ? '0 : p_rdata_q;
  assign lm_cur   = (p_val > lm_q) ? p_val : lm_q;
  assign cmp_le   = (cmp_a <= cmp_b);

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_q <= pmem[p_raddr];
      p_zero_q  <= (p_raddr == '0);
    end
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= smem[s_raddr];
    end
  end

  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    k_d        = k_q;
    iss_done_d = iss_done_q;
    iss_v_d    = 1'b0;
    iss_idx_d  = iss_idx_q;
    min_d      = min_q;
    i_d        = i_q;
    j_d        = j_q;
    lm_d       = lm_q;
    best_d     = best_q;
    p_we       = 1'b0;
    p_re       = 1'b0;
    s_we       = 1'b0;
    s_re       = 1'b0;
    p_waddr    = AddrW'(cnt_q + 1'b1);
    p_raddr    = '0;
    s_waddr    = AddrW'(iss_idx_q);
    s_raddr    = '0;
    p_wdata    = sum_q + samp_ext + off_ext;
    cmp_a      = p_val;
    cmp_b      = min_q;
    s_wdata    = p_val;
    done_o     = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cnt_q < cnt_t'(MaxSamples)) begin
            p_we  = 1'b1;
            sum_d = p_wdata;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d    = StSuf;
            k_d        = cnt_d;
            iss_done_d = 1'b0;
          end
        end
      end
      StSuf: begin
        // fetch P[k] walking down; fold it into the running minimum in the next cycle
        if (!iss_done_q) begin
          p_re      = 1'b1;
          p_raddr   = AddrW'(k_q);
          iss_v_d   = 1'b1;
          iss_idx_d = k_q;
          if (k_q == '0) begin
            iss_done_d = 1'b1;
          end else begin
            k_d = k_q - 1'b1;
          end
        end
        if (iss_v_q) begin
          s_we    = 1'b1;
          s_wdata = ((iss_idx_q == cnt_q) || cmp_le) ? p_val : min_q;
          min_d   = s_wdata;
          if (iss_idx_q == '0) begin
            state_d = StWpre;
          end
        end
      end
      StWpre: begin
        p_re    = 1'b1;
        s_re    = 1'b1;
        i_d     = '0;
        j_d     = '0;
        lm_d    = '0;
        best_d  = '0;
        state_d = StWalk;
      end
      StWalk: begin
        cmp_a = s_rdata_q;
        cmp_b = lm_cur;
        if ((i_q > cnt_q) || (j_q > cnt_q)) begin
          state_d = StDone;
        end else begin
          lm_d = lm_cur;
          if (cmp_le) begin
            if ((j_q > i_q) && ((j_q - i_q) > best_q)) begin
              best_d = j_q - i_q;
            end
            j_d = j_q + 1'b1;
          end else begin
            i_d = i_q + 1'b1;
          end
          p_raddr = AddrW'(i_d);
          s_raddr = AddrW'(j_d);
          p_re    = (i_d <= cnt_q);
          s_re    = (j_d <= cnt_q);
        end
      end
      StDone: begin
        done_o  = 1'b1;
        sum_d   = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign span_length_o = SpanW'(best_q);
  assign overflow_o    = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      offset_q   <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      k_q        <= '0;
      iss_done_q <= 1'b0;
      iss_v_q    <= 1'b0;
      iss_idx_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      best_q     <= '0;
    end else begin
      state_q    <= state_d;
      if (offset_we_i) begin
        offset_q <= offset_i;
      end
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      k_q        <= k_d;
      iss_done_q <= iss_done_d;
      iss_v_q    <= iss_v_d;
      iss_idx_q  <= iss_idx_d;
      i_q        <= i_d;
      j_q        <= j_d;
      best_q     <= best_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    lm_q  <= lm_d;
  end

  // checks
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block not idle after result");

  a_load_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_i) |=> !busy)
    else $error("non-final sample made block busy");

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (cnt_q != '0))
    else $error("search started on empty block");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (i_q <= j_q))
    else $error("walk left pointer passed right pointer");

endmodule

`default_nettype wire

/* sim/lnss_span_checker.sv */
// Checker for the span search: predicts each block's result and compares it.
`timescale 1ns / 1ps

module lnss_span_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire lnss_pkg::sample_t sample_i,
  input  wire logic              last_i,
  input  wire logic              offset_we_i,
  input  wire lnss_pkg::sample_t offset_i,
  input  wire logic              done_i,
  input  wire lnss_pkg::span_t   span_length_i,
  input  wire logic              overflow_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  import lnss_pkg::*;

  localparam int unsigned ExpDepth = 4;  // at most one block is in flight

  typedef struct packed {
    span_t span_length;
    logic  overflow;
  } span_result_t;

  span_result_t expected_spans[ExpDepth];
  int unsigned  exp_wr_count;
  int unsigned  exp_rd_count;
  sum_t         prefix_sums[0:MaxSamples];
  sum_t         running_sum;
  sample_t      offset_now;
  int unsigned  block_len;
  logic         dropped_seen;
  int           mismatch_count;

  assign fail_count_o = mismatch_count;
  assign pending_o    = int'(exp_wr_count - exp_rd_count);

  // Largest j - i with P[j] <= P[i] over P[0..n]: suffix minima, then a
  // two-pointer walk against the running maximum from the left.
  function automatic span_t best_run_length(input int unsigned n);
    sum_t        tail_min[0:MaxSamples];
    sum_t        lead_max;
    int unsigned i;
    int unsigned j;
    int unsigned best;
    tail_min[n] = prefix_sums[n];
    for (int k = n; k > 0; k--) begin
      tail_min[k-1] = (prefix_sums[k-1] < tail_min[k]) ? prefix_sums[k-1] : tail_min[k];
    end
    i = 0;
    j = 0;
    best = 0;
    lead_max = prefix_sums[0];
    while (i <= n && j <= n) begin
      if (tail_min[j] <= lead_max) begin
        if (j > i && j - i > best) best = j - i;
        j++;
      end else begin
        i++;
        if (i <= n && prefix_sums[i] > lead_max) lead_max = prefix_sums[i];
      end
    end
    return span_t'(best);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_result_t got;
    span_result_t want;
    if (!rst_ni) begin
      exp_wr_count   = 0;
      exp_rd_count   = 0;
      running_sum    = '0;
      block_len      = 0;
      dropped_seen   = 1'b0;
      offset_now     = '0;
      prefix_sums[0] = '0;
      mismatch_count = 0;
    end else begin
      // results first: a new item at the same edge belongs to the next block
      if (done_i) begin
        got.span_length = span_length_i;
        got.overflow    = overflow_i;
        if (exp_wr_count == exp_rd_count) begin
          $display("%0t: unexpected result span_length=%0d overflow=%0b",
                   $time, got.span_length, got.overflow);
          mismatch_count++;
        end else begin
          want = expected_spans[exp_rd_count % ExpDepth];
          exp_rd_count++;
          if (got.span_length !== want.span_length) begin
            $display("%0t: span_length mismatch: expected %0d, actual %0d",
                     $time, want.span_length, got.span_length);
            mismatch_count++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, want.overflow, got.overflow);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (block_len < MaxSamples) begin
          running_sum = running_sum + sum_t'(sample_i) + sum_t'(offset_now);
          block_len++;
          prefix_sums[block_len] = running_sum;
        end else begin
          dropped_seen = 1'b1;  // past depth: sample dropped
        end
        if (last_i) begin
          want.span_length = best_run_length(block_len);
          want.overflow    = dropped_seen;
          if (exp_wr_count - exp_rd_count >= ExpDepth) begin
            $display("%0t: result missing: expected span_length=%0d, actual none",
                     $time, expected_spans[exp_rd_count % ExpDepth].span_length);
            mismatch_count++;
            exp_rd_count++;
          end
          expected_spans[exp_wr_count % ExpDepth] = want;
          exp_wr_count++;
          running_sum  = '0;
          block_len    = 0;
          dropped_seen = 1'b0;
        end
      end
      if (offset_we_i) offset_now = offset_i;
    end
  end

endmodule

/* sim/tb_longest_nonpositive_sum_span.sv */
// Testbench top: clock, reset, stimulus and verdict for the span search block.
`timescale 1ns / 1ps

module tb_longest_nonpositive_sum_span;
  import lnss_pkg::*;

  localparam int QuietLimit = 20000;  // cycles with no item, result or write

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  sample_t sample_in;
  logic    last_in;
  logic    offset_we;
  sample_t offset_in;
  logic    done;
  span_t   span_length;
  logic    overflow;
  int      fail_count;
  int      pending;

  int      idle_pct;    // chance per cycle that the sender holds off
  int      offset_now;  // mirror of the offset last written
  int      quiet_cycles;

  longest_nonpositive_sum_span u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .sample_i     (sample_in),
    .last_i       (last_in),
    .offset_we_i  (offset_we),
    .offset_i     (offset_in),
    .done_o       (done),
    .span_length_o(span_length),
    .overflow_o   (overflow)
  );

  lnss_span_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .sample_i     (sample_in),
    .last_i       (last_in),
    .offset_we_i  (offset_we),
    .offset_i     (offset_in),
    .done_i       (done),
    .span_length_i(span_length),
    .overflow_i   (overflow),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result stops the run here.
  always @(posedge clk) begin
    if ((start && !busy) || done || offset_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Gap before the next item, geometric in the idle chance of this phase.
  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 64 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  function automatic sample_t clamp16(input int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  // mode 0: any value; 1: near -offset so shifted sums hover around zero;
  // 2: rails only
  function automatic sample_t pick_sample(input int mode);
    case (mode)
      0:       return sample_t'($urandom_range(65535));
      1:       return clamp16(-offset_now + int'($urandom_range(16)) - 8);
      default: return $urandom_range(1) ? sample_t'(32767) : sample_t'(-32768);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return int'($urandom_range(40)) - 20;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // One item: raised at a falling edge, held until taken at a rising edge
  // with busy low. With no gap, start stays high into the next item.
  task automatic send_item(input sample_t s, input logic is_last, input int gap);
    @(negedge clk);
    start     <= 1'b1;
    sample_in <= s;
    last_in   <= is_last;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Offset write only with nothing in flight; spare idle cycles before the
  // write cover the load of a sample that causes no result.
  task automatic write_offset(input int v);
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0 && !busy);
    repeat (4) @(negedge clk);
    offset_we <= 1'b1;
    offset_in <= sample_t'(v);
    offset_now = v;
    @(negedge clk);
    offset_we <= 1'b0;
  endtask

  task automatic send_block(input int len, input int mode, input bit mid_writes);
    for (int k = 0; k < len; k++) begin
      // offset change between samples of the same block
      if (mid_writes && k > 0 && $urandom_range(19) == 0) write_offset(pick_offset());
      send_item(pick_sample(mode), k == len - 1, pick_gap());
    end
  endtask

  initial begin
    int phase_pct[4];
    int len;
    start        = 1'b0;
    sample_in    = '0;
    last_in      = 1'b0;
    offset_we    = 1'b0;
    offset_in    = '0;
    offset_now   = 0;
    idle_pct     = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single samples, rails, offset rails, mid-block offset change.
    write_offset(0);
    send_item(16'sd0, 1'b1, 0);            // zero sum counts: span 1
    send_item(16'sd1, 1'b1, 0);            // nothing qualifies: span 0
    send_item(-16'sd1, 1'b1, 0);
    send_item(16'sd32767, 1'b0, 0);
    send_item(-16'sd32768, 1'b1, 0);
    send_item(-16'sd32768, 1'b0, 0);
    send_item(16'sd32767, 1'b0, 0);
    send_item(16'sd32767, 1'b0, 0);
    send_item(-16'sd32768, 1'b1, 0);
    write_offset(-32768);                   // max sample shifted to -1
    repeat (2) send_item(16'sd32767, 1'b0, 0);
    send_item(16'sd32767, 1'b1, 0);
    write_offset(32767);
    send_item(16'sd32767, 1'b1, 0);
    send_item(-16'sd32768, 1'b0, 0);
    send_item(-16'sd32768, 1'b1, 0);
    write_offset(5);
    send_item(16'sd2, 1'b0, 0);
    write_offset(-10);                      // second sample uses new offset
    send_item(16'sd2, 1'b1, 0);
    write_offset(0);
    send_item(16'sd5, 1'b0, 1);
    send_item(-16'sd3, 1'b0, 0);
    send_item(-16'sd3, 1'b0, 2);
    send_item(16'sd4, 1'b0, 0);
    send_item(-16'sd2, 1'b1, 0);

    // Random phases: no idling; sender idle 83%; no idling again (results
    // cannot be held off); sender idle 37%.
    phase_pct = '{0, 83, 0, 37};
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      write_offset(pick_offset());
      send_block($urandom_range(60, 30), 1, 1'b0);
      for (int b = 0; b < 7; b++) begin
        if ($urandom_range(4) == 0) write_offset(pick_offset());
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        case ($urandom_range(9))
          0, 1:    send_block(len, 0, 1'b1);
          2:       send_block(len, 2, 1'b0);
          default: send_block(len, 1, 1'b1);
        endcase
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lnss_pkg.sv
hw/rtl/longest_nonpositive_sum_span.sv
sim/lnss_span_checker.sv
sim/tb_longest_nonpositive_sum_span.sv
